FILE: sv/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the LZW hash dictionary encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int CODE_BITS           = 12;
    localparam int TABLE_SIZE_DEF      = 4919;
    localparam int FIRST_DICT_CODE_DEF = 257;
    localparam int OUT_DEPTH           = 4;
    localparam int OUT_CNT_W           = $clog2(OUT_DEPTH + 1);

    localparam logic [CODE_BITS-1:0] CODE_LIMIT = {CODE_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } lzw_in_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 last_code;
    } lzw_out_t;

    // head of the input queue as seen by the back end
    typedef struct packed {
        logic    valid;
        lzw_in_t beat;
    } lzw_head_t;

    typedef struct packed {
        logic                 valid;
        logic [CODE_BITS-1:0] prefix;
        logic [7:0]           data_byte;
        logic [CODE_BITS-1:0] code;
    } lzw_entry_t;

endpackage

FILE: sv/lzw_hash_dictionary_encoder.sv
// ----------------------------------------------------------------------------
// lzw_hash_dictionary_encoder
// LZW encoder with an open-addressed hash dictionary.
//
//   channel | direction | handshake           | payload
//   input   | in        | push / full         | item   (data_byte, end_of_stream)
//   result  | out       | pop / empty         | result (code, last_code)
//
// In the back end a byte passes through S_MOD, S_READ and S_CMP, a miss also
// through S_EMIT_MISS; an extra collision probe repeats S_READ and S_CMP, an
// end_of_stream byte adds S_EMIT_LAST and the first byte of a stream skips the
// probe. S_MOD reduces an out-of-range first probe by repeated subtraction.
// After reset and after every end_of_stream byte a clearing pass writes all
// TABLE_SIZE entries, one a cycle; bytes queue up but are not processed.
// The input queue holds two bytes and the result queue four results; the back
// end takes a byte only while the result queue has room for two more results.
// ----------------------------------------------------------------------------
module lzw_hash_dictionary_encoder
#(
    parameter int TABLE_SIZE      = lzw_pkg::TABLE_SIZE_DEF,
    parameter int FIRST_DICT_CODE = lzw_pkg::FIRST_DICT_CODE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lzw_pkg::lzw_in_t  item,
    output logic              empty,
    input  logic              pop,
    output lzw_pkg::lzw_out_t result
);
    import lzw_pkg::*;

    lzw_head_t            head;
    logic                 take;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 res_push;
    lzw_out_t             res_beat;

    lzw_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (take),
        .head  (head)
    );

    lzw_engine
    #(
        .TABLE_SIZE      (TABLE_SIZE),
        .FIRST_DICT_CODE (FIRST_DICT_CODE)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .take      (take),
        .out_count (out_count),
        .res_push  (res_push),
        .res_out   (res_beat)
    );

    lzw_out_queue u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_beat),
        .count    (out_count),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

FILE: sv/lzw_front.sv
// ----------------------------------------------------------------------------
// lzw_front
// Two-entry input queue; presents the oldest byte to the back end.
// ----------------------------------------------------------------------------
module lzw_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lzw_pkg::lzw_in_t   item,
    input  logic               take,
    output lzw_pkg::lzw_head_t head
);
    import lzw_pkg::*;

    lzw_in_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_take;

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign do_take   = take && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.beat  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_take})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: sv/lzw_out_queue.sv
// ----------------------------------------------------------------------------
// lzw_out_queue
// Result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module lzw_out_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_push,
    input  lzw_pkg::lzw_out_t                 res_in,
    output logic [lzw_pkg::OUT_CNT_W-1:0]     count,
    output logic                              empty,
    input  logic                              pop,
    output lzw_pkg::lzw_out_t                 result
);
    import lzw_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);

    lzw_out_t           q_reg [OUT_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;
    logic               do_pop;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign count  = cnt_reg;
    assign result = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({res_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: sv/lzw_engine.sv
// ----------------------------------------------------------------------------
// lzw_engine
// Back end: hash probe sequencer over the single-port dictionary memory.
// ----------------------------------------------------------------------------
module lzw_engine
#(
    parameter int TABLE_SIZE      = lzw_pkg::TABLE_SIZE_DEF,
    parameter int FIRST_DICT_CODE = lzw_pkg::FIRST_DICT_CODE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzw_pkg::lzw_head_t            head,
    output logic                          take,
    input  logic [lzw_pkg::OUT_CNT_W-1:0] out_count,
    output logic                          res_push,
    output lzw_pkg::lzw_out_t             res_out
);
    import lzw_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int NW = $clog2(TABLE_SIZE + 1);
    localparam int CW = CODE_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CMP,
        S_EMIT_MISS,
        S_EMIT_LAST
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  prefix_reg;
    logic           pvalid_reg;
    logic [CW-1:0]  nfc_reg;
    logic [7:0]     byte_reg;
    logic           eos_reg;
    logic [CW-1:0]  mod_reg;
    logic [IW-1:0]  slot_reg;
    logic [IW-1:0]  step_reg;
    logic [NW-1:0]  n_reg;
    logic [IW-1:0]  clr_reg;
    logic           push_reg;
    lzw_out_t       res_reg;

    logic [$bits(lzw_entry_t)-1:0] mem [TABLE_SIZE];
    logic [$bits(lzw_entry_t)-1:0] rdata_reg;
    lzw_entry_t     rd_entry;
    lzw_entry_t     wr_entry;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic           hit;
    logic           can_add;
    logic [IW-1:0]  slot_step;
    logic [OUT_CNT_W:0] out_used;

    assign rd_entry = lzw_entry_t'(rdata_reg);
    assign hit      = rd_entry.valid && (rd_entry.prefix == prefix_reg)
                      && (rd_entry.data_byte == byte_reg);
    assign can_add  = (nfc_reg < CODE_LIMIT);
    assign slot_step = (slot_reg >= step_reg) ? (slot_reg - step_reg)
                       : (slot_reg + IW'(TABLE_SIZE) - step_reg);
    // room for two results, counting one still on its way in
    assign out_used = {1'b0, out_count} + {{OUT_CNT_W{1'b0}}, push_reg};
    assign take     = (state_reg == S_IDLE) && head.valid
                      && (out_used <= (OUT_CNT_W+1)'(OUT_DEPTH - 2));
    assign res_push = push_reg;
    assign res_out  = res_reg;

    always_comb
    begin
        wr_entry           = '0;
        mem_we             = 1'b0;
        mem_waddr          = slot_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
        end
        else if ((state_reg == S_CMP) && !rd_entry.valid && can_add)
        begin
            mem_we             = 1'b1;
            wr_entry.valid     = 1'b1;
            wr_entry.prefix    = prefix_reg;
            wr_entry.data_byte = byte_reg;
            wr_entry.code      = nfc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= wr_entry;
        end
        rdata_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            prefix_reg <= '0;
            pvalid_reg <= 1'b0;
            nfc_reg    <= CW'(FIRST_DICT_CODE);
            byte_reg   <= '0;
            eos_reg    <= 1'b0;
            mod_reg    <= '0;
            slot_reg   <= '0;
            step_reg   <= '0;
            n_reg      <= '0;
            clr_reg    <= '0;
            push_reg   <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            push_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(TABLE_SIZE - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        byte_reg <= head.beat.data_byte;
                        eos_reg  <= head.beat.end_of_stream;
                        if (!pvalid_reg)
                        begin
                            prefix_reg <= CW'(head.beat.data_byte);
                            pvalid_reg <= 1'b1;
                            state_reg  <= head.beat.end_of_stream ? S_EMIT_LAST : S_IDLE;
                        end
                        else
                        begin
                            mod_reg   <= {head.beat.data_byte, {(CW-8){1'b0}}} ^ prefix_reg;
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    // reduce the first probe one subtraction a cycle
                    if (32'(mod_reg) >= 32'(TABLE_SIZE))
                    begin
                        mod_reg <= mod_reg - CW'(TABLE_SIZE);
                    end
                    else
                    begin
                        slot_reg  <= IW'(mod_reg);
                        step_reg  <= (mod_reg == '0) ? IW'(1)
                                     : (IW'(TABLE_SIZE) - IW'(mod_reg));
                        n_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        prefix_reg <= rd_entry.code;
                        state_reg  <= eos_reg ? S_EMIT_LAST : S_IDLE;
                    end
                    else if (!rd_entry.valid)
                    begin
                        if (can_add)
                        begin
                            nfc_reg <= nfc_reg + 1'b1;
                        end
                        state_reg <= S_EMIT_MISS;
                    end
                    else if (n_reg == NW'(TABLE_SIZE - 1))
                    begin
                        // every slot probed: miss without a new entry
                        state_reg <= S_EMIT_MISS;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        slot_reg  <= slot_step;
                        state_reg <= S_READ;
                    end
                end
                S_EMIT_MISS:
                begin
                    push_reg          <= 1'b1;
                    res_reg.code      <= prefix_reg;
                    res_reg.last_code <= 1'b0;
                    prefix_reg        <= CW'(byte_reg);
                    state_reg         <= eos_reg ? S_EMIT_LAST : S_IDLE;
                end
                S_EMIT_LAST:
                begin
                    push_reg          <= 1'b1;
                    res_reg.code      <= prefix_reg;
                    res_reg.last_code <= 1'b1;
                    prefix_reg        <= '0;
                    pvalid_reg        <= 1'b0;
                    nfc_reg           <= CW'(FIRST_DICT_CODE);
                    clr_reg           <= '0;
                    state_reg         <= S_CLEAR;
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

FILE: sv/lzw_checker.sv
// ----------------------------------------------------------------------------
// lzw_checker
// Port-level assertions for the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzw_checker
#(
    parameter int FIRST_DICT_CODE = lzw_pkg::FIRST_DICT_CODE_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input lzw_pkg::lzw_in_t  item,
    input logic              empty,
    input logic              pop,
    input lzw_pkg::lzw_out_t result
);
    import lzw_pkg::*;

    // hold a waiting result beat until it is taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("result beat changed while stalled");

    a_no_limit_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.code != CODE_LIMIT))
        else $error("reserved top code emitted");

    a_no_gap_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((32'(result.code) < 256) || (32'(result.code) >= FIRST_DICT_CODE)))
        else $error("code below first dictionary code emitted");

endmodule

bind lzw_hash_dictionary_encoder lzw_checker #(.FIRST_DICT_CODE(FIRST_DICT_CODE)) u_chk (.*);
